### rtl/bse_pkg.sv
// Shared types and constants for the beacon SSID element extractor.
// Depends on nothing; used by the top level and its port checker.
package bse_pkg;

  // SSID buffer geometry
  localparam int SSID_BUFFER_BYTES = 32;
  localparam int BUF_AW = (SSID_BUFFER_BYTES > 1) ? $clog2(SSID_BUFFER_BYTES) : 1;
  localparam int CNT_W = $clog2(SSID_BUFFER_BYTES + 1);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LIMIT_W = 6;
  localparam int KIND_W = 3;

  // Copy limit after reset
  localparam logic [LIMIT_W-1:0] COPY_LIMIT_RESET = LIMIT_W'(32);

  // Element id that marks the SSID
  localparam logic [BYTE_W-1:0] SSID_ELEMENT_ID = 8'h00;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    K_CHAR   = 3'd0,
    K_DONE   = 3'd1,
    K_ZERO   = 3'd2,
    K_HIDDEN = 3'd3,
    K_NONE   = 3'd4
  } kind_t;

  // Element walk phases
  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

endpackage

### rtl/beacon_ssid_element_extractor.sv
// Beacon SSID element extractor: walks tagged elements and reports the SSID.
// Depends on bse_pkg for kinds, phases and buffer geometry.
//
//   channel   signals                                        direction
//   --------  ---------------------------------------------  ---------
//   in        in_valid, in_ready, data_byte, last_byte       request in
//   cfg       cfg_valid, cfg_ready, cfg_data (copy_limit)    request in
//   out       out_valid, out_ready, kind, char_value,        request out
//             ssid_length, last_of_run
//
// A region byte is taken whenever the output register is free and no SSID is being emitted.
// While a visible SSID is emitted no byte is taken: each character is one
// registered read of the buffer RAM followed by a load of the output register,
// and a status result follows the last character.
// rst (synchronous) restores copy_limit to 32 and restarts the walk; the
// buffer RAM is not cleared. A stalled output holds input acceptance.
module beacon_ssid_element_extractor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bse_pkg::BYTE_W-1:0]       data_byte,
  input  logic                             last_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bse_pkg::LIMIT_W-1:0]      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bse_pkg::KIND_W-1:0]       kind,
  output logic [bse_pkg::BYTE_W-1:0]       char_value,
  output logic [bse_pkg::BYTE_W-1:0]       ssid_length,
  output logic                             last_of_run
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t                          state;
  bse_pkg::phase_t                 parse_phase;
  logic                            element_is_ssid;
  logic [bse_pkg::BYTE_W-1:0]      element_length;
  logic [bse_pkg::BYTE_W-1:0]      bytes_remaining;
  logic                            all_zero_so_far;
  logic                            outcome_reported;
  logic [bse_pkg::LIMIT_W-1:0]     copy_limit;
  logic [bse_pkg::CNT_W-1:0]       copy_count;
  logic [bse_pkg::CNT_W-1:0]       char_idx;

  // SSID buffer RAM
  logic [bse_pkg::BYTE_W-1:0]      ssid_buffer [bse_pkg::SSID_BUFFER_BYTES];
  logic [bse_pkg::BYTE_W-1:0]      rd_data;
  logic                            buf_we;
  logic [bse_pkg::BUF_AW-1:0]      buf_waddr;

  logic                            accept;
  logic                            out_free;
  logic [bse_pkg::BYTE_W-1:0]      pos;
  logic [bse_pkg::BYTE_W-1:0]      rem_dec;
  logic                            allz_upd;
  logic                            do_report;
  logic [bse_pkg::BYTE_W-1:0]      rep_len;
  logic                            rep_allz;
  logic [bse_pkg::BYTE_W-1:0]      lim_a;
  logic [bse_pkg::BYTE_W-1:0]      lim_b;
  logic [bse_pkg::CNT_W-1:0]       rep_count;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Decode the byte against the current walk phase
  always_comb begin
    pos       = element_length - bytes_remaining;
    rem_dec   = bytes_remaining - 8'd1;
    allz_upd  = all_zero_so_far && (data_byte == 8'h00);
    do_report = 1'b0;
    rep_len   = element_length;
    rep_allz  = allz_upd;
    unique case (parse_phase)
      bse_pkg::PH_LEN: begin
        do_report = (data_byte == 8'h00) && element_is_ssid;
        rep_len   = data_byte;
        rep_allz  = 1'b1;
      end
      bse_pkg::PH_DATA: begin
        do_report = (rem_dec == 8'h00) && element_is_ssid;
      end
      default: begin
        do_report = 1'b0;
      end
    endcase
    // Characters copied: least of length, copy limit and buffer size
    lim_a = (rep_len > 8'(copy_limit)) ? 8'(copy_limit) : rep_len;
    lim_b = (lim_a > 8'(bse_pkg::SSID_BUFFER_BYTES)) ? 8'(bse_pkg::SSID_BUFFER_BYTES)
                                                      : lim_a;
    rep_count = lim_b[bse_pkg::CNT_W-1:0];
    buf_we    = accept && (parse_phase == bse_pkg::PH_DATA) && element_is_ssid &&
                (pos < 8'(bse_pkg::SSID_BUFFER_BYTES));
    buf_waddr = pos[bse_pkg::BUF_AW-1:0];
  end

  // Buffer write on SSID data bytes; a write lands before the first read
  // that can see it, since reads start the cycle after the last data byte
  always_ff @(posedge clk) begin
    if (buf_we) begin
      ssid_buffer[buf_waddr] <= data_byte;
    end
    rd_data <= ssid_buffer[char_idx[bse_pkg::BUF_AW-1:0]];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_limit <= bse_pkg::COPY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      copy_limit <= cfg_data;
    end
  end

  // Element walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= bse_pkg::PH_ID;
      element_is_ssid  <= 1'b0;
      element_length   <= '0;
      bytes_remaining  <= '0;
      all_zero_so_far  <= 1'b1;
      outcome_reported <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        // restart for the next region
        parse_phase      <= bse_pkg::PH_ID;
        element_is_ssid  <= 1'b0;
        element_length   <= '0;
        bytes_remaining  <= '0;
        all_zero_so_far  <= 1'b1;
        outcome_reported <= 1'b0;
      end else begin
        unique case (parse_phase)
          bse_pkg::PH_ID: begin
            element_is_ssid <= (data_byte == bse_pkg::SSID_ELEMENT_ID);
            parse_phase     <= bse_pkg::PH_LEN;
          end
          bse_pkg::PH_LEN: begin
            element_length  <= data_byte;
            bytes_remaining <= data_byte;
            all_zero_so_far <= 1'b1;
            if (data_byte != 8'h00) begin
              parse_phase <= bse_pkg::PH_DATA;
            end else if (element_is_ssid) begin
              parse_phase      <= bse_pkg::PH_DONE;
              outcome_reported <= 1'b1;
            end else begin
              parse_phase <= bse_pkg::PH_ID;
            end
          end
          bse_pkg::PH_DATA: begin
            bytes_remaining <= rem_dec;
            if (element_is_ssid) begin
              all_zero_so_far <= allz_upd;
            end
            if (rem_dec == 8'h00) begin
              if (element_is_ssid) begin
                parse_phase      <= bse_pkg::PH_DONE;
                outcome_reported <= 1'b1;
              end else begin
                parse_phase <= bse_pkg::PH_ID;
              end
            end
          end
          default: begin
            parse_phase <= bse_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  // Emission sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      char_idx  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (do_report) begin
              if (rep_len == 8'h00) begin
                out_valid   <= 1'b1;
                kind        <= bse_pkg::K_ZERO;
                char_value  <= '0;
                ssid_length <= '0;
                last_of_run <= 1'b1;
              end else if (rep_allz) begin
                out_valid   <= 1'b1;
                kind        <= bse_pkg::K_HIDDEN;
                char_value  <= '0;
                ssid_length <= rep_len;
                last_of_run <= 1'b1;
              end else if (rep_count == '0) begin
                out_valid   <= 1'b1;
                kind        <= bse_pkg::K_DONE;
                char_value  <= '0;
                ssid_length <= '0;
                last_of_run <= 1'b1;
              end else begin
                copy_count <= rep_count;
                char_idx   <= '0;
                state      <= ST_READ;
              end
            end else if (last_byte && !outcome_reported) begin
              out_valid   <= 1'b1;
              kind        <= bse_pkg::K_NONE;
              char_value  <= '0;
              ssid_length <= '0;
              last_of_run <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= bse_pkg::K_CHAR;
            char_value  <= rd_data;
            ssid_length <= '0;
            last_of_run <= 1'b0;
            if (char_idx + bse_pkg::CNT_W'(1) == copy_count) begin
              state <= ST_STATUS;
            end else begin
              char_idx <= char_idx + bse_pkg::CNT_W'(1);
              state    <= ST_READ;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= bse_pkg::K_DONE;
            char_value  <= '0;
            ssid_length <= 8'(copy_count);
            last_of_run <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bse_port_checker.sv
// Port-level checks for the beacon SSID element extractor, bound to its top.
// Depends on bse_pkg for result kinds.
module bse_port_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bse_pkg::KIND_W-1:0]   kind,
  input logic [bse_pkg::BYTE_W-1:0]   char_value,
  input logic [bse_pkg::BYTE_W-1:0]   ssid_length,
  input logic                         last_of_run
);

  // Character results are never the end of a run and carry no length
  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bse_pkg::K_CHAR) |-> !last_of_run && (ssid_length == '0))
    else $error("character result with status fields set");

  // Status results end the run and carry no character
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != bse_pkg::K_CHAR) |-> last_of_run && (char_value == '0))
    else $error("status result with bad fields");

  // No new byte is taken while an SSID is still being emitted
  a_hold_during_chars: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bse_pkg::K_CHAR) |-> !in_ready)
    else $error("input taken in the middle of an SSID");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value))
    else $error("stalled result changed");

endmodule

bind beacon_ssid_element_extractor bse_port_checker u_bse_port_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .char_value  (char_value),
  .ssid_length (ssid_length),
  .last_of_run (last_of_run)
);

### tb/beacon_ssid_element_extractor_test.sv
// Self-checking testbench for beacon_ssid_element_extractor: tagged-element regions in,
// SSID characters and outcome statuses out, checked against an in-bench SSID parser.
// Depends on bse_pkg and the beacon_ssid_element_extractor RTL.
module beacon_ssid_element_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;   // cycles with no request moved before giving up
  localparam int SETTLE_CYCLES = 8;   // let in-flight region bytes finish before a config write
  localparam int TAIL_CYCLES = 80;    // wait after the last expectation for stray results
  localparam int RANDOM_BYTES = 20;

  typedef logic [bse_pkg::BYTE_W-1:0]  byte_t;
  typedef logic [bse_pkg::LIMIT_W-1:0] limit_t;

  typedef struct {
    bse_pkg::kind_t    kind;
    byte_t             char_value;
    byte_t             ssid_length;
    logic              last_of_run;
  } ssid_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  byte_t               data_byte = '0;
  logic                last_byte = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  limit_t              cfg_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [bse_pkg::KIND_W-1:0] kind;
  byte_t               char_value;
  byte_t               ssid_length;
  logic                last_of_run;

  // SSID parser state mirrored from the block
  bse_pkg::phase_t     walk_phase = bse_pkg::PH_ID;
  logic                in_ssid = 1'b0;
  byte_t               elem_len = '0;
  byte_t               bytes_left = '0;
  logic                zero_so_far = 1'b1;
  logic                outcome_done = 1'b0;
  byte_t               ssid_copy [bse_pkg::SSID_BUFFER_BYTES];
  limit_t              copy_cap = bse_pkg::COPY_LIMIT_RESET;

  ssid_result_t        results_due [$];
  byte_t               pending_region [$];
  int                  bytes_sent = 0;
  int                  mismatches = 0;
  int                  idle_cycles = 0;
  bit                  sender_steady = 1'b0;

  beacon_ssid_element_extractor dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .char_value  (char_value),
    .ssid_length (ssid_length),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly zero or short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void expect_result(bse_pkg::kind_t k, byte_t ch, byte_t len, logic fin);
    ssid_result_t r;
    r.kind = k;
    r.char_value = ch;
    r.ssid_length = len;
    r.last_of_run = fin;
    results_due.push_back(r);
  endfunction

  function automatic void restart_walk();
    walk_phase = bse_pkg::PH_ID;
    in_ssid = 1'b0;
    elem_len = '0;
    bytes_left = '0;
    zero_so_far = 1'b1;
    outcome_done = 1'b0;
  endfunction

  // Report the outcome of a completed SSID element
  function automatic void report_ssid();
    int n;
    outcome_done = 1'b1;
    walk_phase = bse_pkg::PH_DONE;
    if (elem_len == 0) begin
      expect_result(bse_pkg::K_ZERO, '0, '0, 1'b1);
    end else if (zero_so_far) begin
      expect_result(bse_pkg::K_HIDDEN, '0, elem_len, 1'b1);
    end else begin
      n = elem_len;
      if (n > copy_cap) n = copy_cap;
      if (n > bse_pkg::SSID_BUFFER_BYTES) n = bse_pkg::SSID_BUFFER_BYTES;
      for (int i = 0; i < n; i++) expect_result(bse_pkg::K_CHAR, ssid_copy[i], '0, 1'b0);
      expect_result(bse_pkg::K_DONE, '0, byte_t'(n), 1'b1);
    end
  endfunction

  // Advance the parser by one accepted region byte
  function automatic void predict_region_byte(byte_t b, logic fin);
    byte_t pos;
    case (walk_phase)
      bse_pkg::PH_ID: begin
        in_ssid = (b == bse_pkg::SSID_ELEMENT_ID);
        walk_phase = bse_pkg::PH_LEN;
      end
      bse_pkg::PH_LEN: begin
        elem_len = b;
        bytes_left = b;
        zero_so_far = 1'b1;
        if (b == 0) begin
          if (in_ssid) report_ssid();
          else walk_phase = bse_pkg::PH_ID;
        end else begin
          walk_phase = bse_pkg::PH_DATA;
        end
      end
      bse_pkg::PH_DATA: begin
        if (in_ssid) begin
          pos = elem_len - bytes_left;
          if (pos < bse_pkg::SSID_BUFFER_BYTES) ssid_copy[pos] = b;
          if (b != 0) zero_so_far = 1'b0;
        end
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
          if (in_ssid) report_ssid();
          else walk_phase = bse_pkg::PH_ID;
        end
      end
      default: begin
      end
    endcase
    // End of region: report not found if nothing came, then restart
    if (fin) begin
      if (!outcome_done) expect_result(bse_pkg::K_NONE, '0, '0, 1'b1);
      restart_walk();
    end
  endfunction

  // Send one region byte; called and returns at a falling edge with in_valid unassigned
  task automatic send_region_byte(input byte_t b, input logic fin);
    int gap;
    data_byte <= b;
    last_byte <= fin;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_region_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    idle_input();
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Write copy_limit only once the block has gone quiet
  task automatic write_copy_limit(input limit_t value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    copy_cap = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_byte(byte_t b);
    pending_region.push_back(b);
  endfunction

  // Append an element; each data byte is zero with the given percent chance
  function automatic void add_element(byte_t id, int len, int zero_pct);
    push_byte(id);
    push_byte(byte_t'(len));
    for (int i = 0; i < len; i++)
      push_byte(($urandom_range(0, 99) < zero_pct) ? 8'h00 : byte_t'($urandom_range(0, 255)));
  endfunction

  // Send the pending region, last_byte on its final byte
  task automatic play_region();
    int count;
    count = pending_region.size();
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) send_region_byte(pending_region[i], i == count - 1);
    pending_region.delete();
  endtask

  task automatic build_random_region();
    int shape;
    int sel;
    int keep;
    shape = $urandom_range(0, 99);
    // Noise: arbitrary bytes
    if (shape < 10) begin
      repeat ($urandom_range(1, 8)) push_byte(byte_t'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2))
      add_element(byte_t'($urandom_range(1, 255)), $urandom_range(0, 5), 10);
    // Regions below 20 carry no SSID element at all
    if (shape >= 20) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) add_element(bse_pkg::SSID_ELEMENT_ID, 0, 0);
      else if (sel < 25) add_element(bse_pkg::SSID_ELEMENT_ID, $urandom_range(1, 8), 100);
      else if (sel < 90) add_element(bse_pkg::SSID_ELEMENT_ID, $urandom_range(1, 12), 10);
      else add_element(bse_pkg::SSID_ELEMENT_ID, $urandom_range(13, 40), 10);
      repeat ($urandom_range(0, 2))
        add_element(byte_t'($urandom_range(0, 255)), $urandom_range(0, 4), 10);
    end
    // Cut some regions short
    if (shape >= 20 && shape < 35) begin
      keep = $urandom_range(1, pending_region.size());
      while (pending_region.size() > keep) void'(pending_region.pop_back());
    end
  endtask

  task automatic test_directed_regions();
    // Empty SSID completing on the final byte
    push_byte(bse_pkg::SSID_ELEMENT_ID); push_byte(8'd0);
    play_region();
    // Hidden SSID, trailing byte ignored
    push_byte(bse_pkg::SSID_ELEMENT_ID); push_byte(8'd2); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'hFF);
    play_region();
    // Skip a vendor element, then a visible SSID with an embedded zero
    push_byte(8'hDD); push_byte(8'd1); push_byte(8'hAA);
    push_byte(bse_pkg::SSID_ELEMENT_ID); push_byte(8'd3); push_byte(8'h61); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h7E);
    play_region();
    // No SSID element: empty element then a short one
    push_byte(8'h32); push_byte(8'd0); push_byte(8'h01); push_byte(8'd1); push_byte(8'h82);
    play_region();
    // SSID cut off by the end of the region
    push_byte(bse_pkg::SSID_ELEMENT_ID); push_byte(8'd5); push_byte(8'h41); push_byte(8'h42);
    play_region();
    // Region of a single byte
    push_byte(bse_pkg::SSID_ELEMENT_ID);
    play_region();
  endtask

  task automatic test_copy_limit_sweep();
    write_copy_limit(limit_t'(0));
    add_element(8'h01, 2, 0); add_element(bse_pkg::SSID_ELEMENT_ID, 6, 0);
    play_region();
    write_copy_limit(limit_t'(1));
    add_element(bse_pkg::SSID_ELEMENT_ID, 4, 0);
    play_region();
    write_copy_limit(limit_t'(5));
    add_element(bse_pkg::SSID_ELEMENT_ID, 9, 20); add_element(8'h03, 1, 0);
    play_region();
    write_copy_limit(limit_t'(32));
    add_element(bse_pkg::SSID_ELEMENT_ID, 8, 5);
    play_region();
    write_copy_limit(limit_t'(63));
    // Zeros up to the buffer end, a nonzero byte past it: not hidden
    add_element(bse_pkg::SSID_ELEMENT_ID, 34, 100);
    pending_region[pending_region.size() - 1] = 8'h5A;
    play_region();
    // Hidden element running past the buffer end
    add_element(bse_pkg::SSID_ELEMENT_ID, 33, 100);
    play_region();
  endtask

  task automatic test_drain_between_regions();
    repeat (2) begin
      add_element(8'h07, 3, 0);
      add_element(bse_pkg::SSID_ELEMENT_ID, $urandom_range(1, 10), 0);
      play_region();
      drain_results();
    end
  endtask

  task automatic test_random_regions();
    int stop_at;
    int r;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 5);
        if (r == 0) write_copy_limit(limit_t'(0));
        else if (r == 1) write_copy_limit(limit_t'(63));
        else write_copy_limit(limit_t'($urandom_range(0, 63)));
      end
      build_random_region();
      play_region();
    end
  endtask

  // Receiver: runs of ready broken by random stalls
  initial begin
    int run;
    int stall;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin : check_result
      ssid_result_t due;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d char %02h length %0d last %0b",
                   kind, char_value, ssid_length, last_of_run);
      end else begin
        due = results_due.pop_front();
        if (kind !== due.kind || char_value !== due.char_value ||
            ssid_length !== due.ssid_length || last_of_run !== due.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d char %02h length %0d last %0b",
                     due.kind, due.char_value, due.ssid_length, due.last_of_run);
            $display("          got kind %0d char %02h length %0d last %0b",
                     kind, char_value, ssid_length, last_of_run);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_regions();
    test_copy_limit_sweep();
    test_drain_between_regions();
    test_random_regions();
    // Wait out every expectation, then watch for strays
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
